[hdl/pfd_pkg.sv]
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared constants and codes for the Playfair digraph decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

  // Square geometry default
  localparam int GRID_SIDE_DEF = 5;

  // Alphabet
  localparam int LETTERS  = 26;
  localparam int LETTER_W = 5;

  localparam logic [LETTER_W-1:0] LETTER_I = LETTER_W'(8);
  localparam logic [LETTER_W-1:0] LETTER_J = LETTER_W'(9);
  localparam logic [LETTER_W-1:0] LETTER_Z = LETTER_W'(25);

  // Operation selector
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_KEY     = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;
  localparam logic [OP_W-1:0] OP_DECRYPT = 2'd3;

  // Result status
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NOTREADY = 1'b1;

  // Stream widths
  localparam int TDATA_W = 16;

endpackage

`default_nettype wire

[hdl/pfd_ram2r.sv]
// ----------------------------------------------------------------------------
// pfd_ram2r
// Synchronous RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_ram2r #(
  parameter int DEPTH = 26,
  parameter int WIDTH = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, hold data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[hdl/pfd_rule.sv]
// ----------------------------------------------------------------------------
// pfd_rule
// Playfair decryption rule: maps the two cipher letter positions to the
// square cells that hold the plain letters.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_rule #(
  parameter int GRID_SIDE = 5,
  localparam int CW    = $clog2(GRID_SIDE),
  localparam int IDX_W = $clog2(GRID_SIDE * GRID_SIDE)
) (
  input  wire logic [2*CW-1:0]  pos_a,   // row in upper half, column in lower
  input  wire logic [2*CW-1:0]  pos_b,
  output logic      [IDX_W-1:0] idx_a,
  output logic      [IDX_W-1:0] idx_b
);

  localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

  logic [CW-1:0] r1, c1, r2, c2;
  logic [CW-1:0] nr1, nc1, nr2, nc2;

  assign r1 = pos_a[2*CW-1:CW];
  assign c1 = pos_a[CW-1:0];
  assign r2 = pos_b[2*CW-1:CW];
  assign c2 = pos_b[CW-1:0];

  // Same row: step left; same column: step up; else swap columns
  always_comb begin
    nr1 = r1;
    nc1 = c1;
    nr2 = r2;
    nc2 = c2;
    if (r1 == r2) begin
      nc1 = (c1 == '0) ? LAST : c1 - 1'b1;
      nc2 = (c2 == '0) ? LAST : c2 - 1'b1;
    end else if (c1 == c2) begin
      nr1 = (r1 == '0) ? LAST : r1 - 1'b1;
      nr2 = (r2 == '0) ? LAST : r2 - 1'b1;
    end else begin
      nc1 = c2;
      nc2 = c1;
    end
  end

  // Row-major cell index
  assign idx_a = IDX_W'(int'(nr1) * GRID_SIDE + int'(nc1));
  assign idx_b = IDX_W'(int'(nr2) * GRID_SIDE + int'(nc2));

endmodule

`default_nettype wire

[hdl/playfair_digraph_decrypt_top.sv]
// ----------------------------------------------------------------------------
// playfair_digraph_decrypt_top
// Builds a Playfair key square from key items and decrypts letter pairs.
//
//  channel  dir  handshake                     content
//  s_axis   in   s_axis_tvalid/s_axis_tready   tuser op, tdata letter_a, letter_b
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata plain_a, plain_b, tuser status
//
// Clear and key items are handled as they are accepted. Finish walks the alphabet
// one letter a cycle through both write ports.
// A decrypt item takes a position-map read, a square read, an output load;
// on an incomplete square it takes only the output load, with no reads.
// Reset clears the used-letter flags, fill count and ready flag; the memories
// need no clearing. A stalled result holds the block in its output state.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_decrypt_top
  import pfd_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,   // [4:0] letter_a, [9:5] letter_b
  input  wire logic [OP_W-1:0]    s_axis_tuser,   // [1:0] op
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [TDATA_W-1:0] m_axis_tdata,   // [4:0] plain_a, [9:5] plain_b
  output logic                    m_axis_tuser    // [0] status
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int IDX_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int POS_W = 2 * CW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FILL = 4'b0010,
    ST_LOOK = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [LETTERS-1:0]   used;
  logic [CNT_W-1:0]     cells_filled;
  logic [CW-1:0]        row, col;
  logic                 square_ready;
  logic [LETTER_W-1:0]  fill_letter;
  logic                 err;

  logic                 out_valid;
  logic [LETTER_W-1:0]  out_a, out_b;
  logic                 out_status;

  logic                 in_acc;
  logic [OP_W-1:0]      op;
  logic [LETTER_W-1:0]  in_a, in_b, key_l, ciph_a, ciph_b;
  logic                 place_req, place_en, place_last;
  logic [LETTER_W-1:0]  place_l;
  logic                 pos_re, out_load;
  logic [POS_W-1:0]     pos_a, pos_b;
  logic [IDX_W-1:0]     idx_a, idx_b;
  logic [LETTER_W-1:0]  sq_a, sq_b;

  // Unpack input item
  assign op     = s_axis_tuser;
  assign in_a   = s_axis_tdata[LETTER_W-1:0];
  assign in_b   = s_axis_tdata[2*LETTER_W-1:LETTER_W];
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Fold J into I; clamp cipher values above Z
  assign key_l  = (in_a == LETTER_J) ? LETTER_I : in_a;
  assign ciph_a = (in_a > LETTER_Z) ? LETTER_Z : ((in_a == LETTER_J) ? LETTER_I : in_a);
  assign ciph_b = (in_b > LETTER_Z) ? LETTER_Z : ((in_b == LETTER_J) ? LETTER_I : in_b);

  // Select the letter to place: a key item or the finish walk
  always_comb begin
    place_req = 1'b0;
    place_l   = fill_letter;
    if (state == ST_FILL) begin
      place_req = (fill_letter != LETTER_J);
    end else if (in_acc && op == OP_KEY && !square_ready && in_a <= LETTER_Z) begin
      place_req = 1'b1;
      place_l   = key_l;
    end
  end

  assign place_en   = place_req && !used[place_l] && (cells_filled < CNT_W'(CELLS));
  assign place_last = place_en && (cells_filled == CNT_W'(CELLS - 1));
  assign pos_re     = in_acc && op == OP_DECRYPT && square_ready;
  assign out_load   = (state == ST_OUT) && (!out_valid || m_axis_tready);

  // Letter position map: row and column of each placed letter
  pfd_ram2r #(
    .DEPTH (LETTERS),
    .WIDTH (POS_W)
  ) u_pos_mem (
    .clk     (clk),
    .we      (place_en),
    .waddr   (place_l),
    .wdata   ({row, col}),
    .re      (pos_re),
    .raddr_a (ciph_a),
    .raddr_b (ciph_b),
    .rdata_a (pos_a),
    .rdata_b (pos_b)
  );

  pfd_rule #(
    .GRID_SIDE (GRID_SIDE)
  ) u_rule (
    .pos_a (pos_a),
    .pos_b (pos_b),
    .idx_a (idx_a),
    .idx_b (idx_b)
  );

  // Key square cells in row-major order
  pfd_ram2r #(
    .DEPTH (CELLS),
    .WIDTH (LETTER_W)
  ) u_sq_mem (
    .clk     (clk),
    .we      (place_en),
    .waddr   (cells_filled[IDX_W-1:0]),
    .wdata   (place_l),
    .re      (state == ST_LOOK),
    .raddr_a (idx_a),
    .raddr_b (idx_b),
    .rdata_a (sq_a),
    .rdata_b (sq_b)
  );

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (op == OP_FINISH && !square_ready) begin
            state_next = ST_FILL;
          end else if (op == OP_DECRYPT) begin
            state_next = square_ready ? ST_LOOK : ST_OUT;
          end
        end
      end
      ST_FILL: begin
        if (place_last || fill_letter == LETTER_W'(LETTERS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_LOOK: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Square build state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      used         <= '0;
      cells_filled <= '0;
      row          <= '0;
      col          <= '0;
      square_ready <= 1'b0;
      fill_letter  <= '0;
      err          <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc && op == OP_CLEAR) begin
        used         <= '0;
        cells_filled <= '0;
        row          <= '0;
        col          <= '0;
        square_ready <= 1'b0;
      end else if (place_en) begin
        used[place_l] <= 1'b1;
        cells_filled  <= cells_filled + 1'b1;
        if (col == CW'(GRID_SIDE - 1)) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
        if (place_last) begin
          square_ready <= 1'b1;
        end
      end
      if (in_acc && op == OP_FINISH) begin
        fill_letter <= '0;
      end else if (state == ST_FILL) begin
        fill_letter <= fill_letter + 1'b1;
      end
      if (in_acc && op == OP_DECRYPT) begin
        err <= !square_ready;
      end
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_a      <= err ? '0 : sq_a;
      out_b      <= err ? '0 : sq_b;
      out_status <= err ? STATUS_NOTREADY : STATUS_OK;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(TDATA_W - 2 * LETTER_W)'(0), out_b, out_a};
  assign m_axis_tuser  = out_status;

`ifndef SYNTHESIS
  a_ready_full : assert property (@(posedge clk) disable iff (rst)
    square_ready |-> cells_filled == CNT_W'(CELLS))
    else $error("square ready with cells missing");

  a_used_count : assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(cells_filled))
    else $error("used flags disagree with fill count");

  a_clear : assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == OP_CLEAR) |=> (cells_filled == '0 && !square_ready))
    else $error("clear item did not empty the square");

  a_look_ready : assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |-> square_ready)
    else $error("lookup on an incomplete square");
`endif

endmodule

`default_nettype wire
